>>> hdl/lookup3_little_endian_hash_defines.svh
// Assertion macros for the lookup3 hash block.
`ifndef LOOKUP3_LITTLE_ENDIAN_HASH_DEFINES_SVH
`define LOOKUP3_LITTLE_ENDIAN_HASH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define L3H_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("l3h assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define L3H_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("l3h assertion failed");

`endif

>>> hdl/l3h_pkg.sv
// Shared types, constants and round functions for the lookup3 hash block.
package l3h_pkg;

  localparam logic [31:0] INIT_CONST  = 32'hdeadbeef;
  localparam logic [3:0]  BLOCK_BYTES = 4'd12;
  localparam logic [2:0]  MIX_LAST    = 3'd5;
  localparam logic [2:0]  FINAL_LAST  = 3'd6;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [3:0]  byte_count;
    logic [31:0] total_length;
    logic [31:0] seed_primary;
    logic [31:0] seed_secondary;
  } in_t;

  typedef struct packed {
    logic [31:0] hash_primary;
    logic [31:0] hash_secondary;
  } out_t;

  // Classified block as it waits for the mixing engine.
  typedef struct packed {
    logic        first;
    logic        last;
    logic        run_final;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] init_val;
    logic [31:0] seed_secondary;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_FINAL,
    ST_EMIT
  } back_state_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
    logic [63:0] dbl;
    dbl = {x, x} << k;
    return dbl[63:32];
  endfunction

  // One line of the reversible mix: x -= z; x ^= rotl(z, k)
  function automatic logic [31:0] mix_x(input logic [31:0] x, input logic [31:0] z,
                                        input logic [4:0] k);
    return (x - z) ^ rotl(z, k);
  endfunction

  // One line of the final mix: x ^= z; x -= rotl(z, k)
  function automatic logic [31:0] fin_x(input logic [31:0] x, input logic [31:0] z,
                                        input logic [4:0] k);
    return (x ^ z) - rotl(z, k);
  endfunction

  // Keeps the valid low bytes of word idx when n bytes of the block are valid.
  function automatic logic [31:0] byte_mask(input logic [3:0] n, input logic [1:0] idx);
    logic [3:0]  base;
    logic [3:0]  rem;
    logic [31:0] m;
    base = {idx, 2'b00};
    rem  = n - base;
    if (n <= base) begin
      m = '0;
    end else if (rem >= 4'd4) begin
      m = '1;
    end else begin
      m = (32'd1 << {rem[1:0], 3'b000}) - 32'd1;
    end
    return m;
  endfunction

endpackage

>>> hdl/l3h_front.sv
// Front end: seeds the initial value, masks the tail block and classifies it.
module l3h_front (
  input  l3h_pkg::in_t    in_data_i,
  output l3h_pkg::entry_t entry_o
);
  import l3h_pkg::*;

  logic [3:0] count;

  always_comb begin
    count = (in_data_i.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : in_data_i.byte_count;

    entry_o.first          = in_data_i.first;
    entry_o.last           = in_data_i.last;
    entry_o.run_final      = in_data_i.last && (count != 4'd0);
    entry_o.init_val       = INIT_CONST + in_data_i.total_length + in_data_i.seed_primary;
    entry_o.seed_secondary = in_data_i.seed_secondary;

    if (in_data_i.last) begin
      entry_o.word0 = in_data_i.word0 & byte_mask(count, 2'd0);
      entry_o.word1 = in_data_i.word1 & byte_mask(count, 2'd1);
      entry_o.word2 = in_data_i.word2 & byte_mask(count, 2'd2);
    end else begin
      entry_o.word0 = in_data_i.word0;
      entry_o.word1 = in_data_i.word1;
      entry_o.word2 = in_data_i.word2;
    end
  end

endmodule

>>> hdl/l3h_queue.sv
// Two-entry queue between the front end and the mixing engine.
module l3h_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  l3h_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output l3h_pkg::entry_t pop_data_o
);
  import l3h_pkg::*;

  entry_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/l3h_back.sv
// Mixing engine: absorbs a block, runs the mix or final mix a line per cycle.
module l3h_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            entry_valid_i,
  input  l3h_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output l3h_pkg::out_t   out_data_o
);
  import l3h_pkg::*;

  back_state_e state_q, state_d;
  logic [2:0]  rnd_q, rnd_d;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q;
  logic        out_load;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d  = state_q;
    rnd_d    = rnd_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    pop_o    = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (entry_valid_i) begin
          pop_o = 1'b1;
          rnd_d = '0;
          a_d   = (entry_i.first ? entry_i.init_val : a_q) + entry_i.word0;
          b_d   = (entry_i.first ? entry_i.init_val : b_q) + entry_i.word1;
          c_d   = (entry_i.first ? entry_i.init_val : c_q)
                + (entry_i.first ? entry_i.seed_secondary : 32'd0) + entry_i.word2;
          if (!entry_i.last) begin
            state_d = ST_MIX;
          end else if (entry_i.run_final) begin
            state_d = ST_FINAL;
          end else begin
            state_d = ST_EMIT;  // empty message: no final mix
          end
        end
      end
      ST_MIX: begin
        case (rnd_q)
          3'd0: begin a_d = mix_x(a_q, c_q, 5'd4);  c_d = c_q + b_q; end
          3'd1: begin b_d = mix_x(b_q, a_q, 5'd6);  a_d = a_q + c_q; end
          3'd2: begin c_d = mix_x(c_q, b_q, 5'd8);  b_d = b_q + a_q; end
          3'd3: begin a_d = mix_x(a_q, c_q, 5'd16); c_d = c_q + b_q; end
          3'd4: begin b_d = mix_x(b_q, a_q, 5'd19); a_d = a_q + c_q; end
          3'd5: begin c_d = mix_x(c_q, b_q, 5'd4);  b_d = b_q + a_q; end
          default: ;
        endcase
        if (rnd_q == MIX_LAST) begin
          state_d = ST_IDLE;
        end else begin
          rnd_d = rnd_q + 3'd1;
        end
      end
      ST_FINAL: begin
        case (rnd_q)
          3'd0: c_d = fin_x(c_q, b_q, 5'd14);
          3'd1: a_d = fin_x(a_q, c_q, 5'd11);
          3'd2: b_d = fin_x(b_q, a_q, 5'd25);
          3'd3: c_d = fin_x(c_q, b_q, 5'd16);
          3'd4: a_d = fin_x(a_q, c_q, 5'd4);
          3'd5: b_d = fin_x(b_q, a_q, 5'd14);
          3'd6: c_d = fin_x(c_q, b_q, 5'd24);
          default: ;
        endcase
        if (rnd_q == FINAL_LAST) begin
          state_d = ST_EMIT;
        end else begin
          rnd_d = rnd_q + 3'd1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      a_q         <= a_d;
      b_q         <= b_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.hash_primary   <= c_q;
      out_q.hash_secondary <= b_q;
    end
  end

endmodule

>>> hdl/lookup3_little_endian_hash.sv
// Top level of the lookup3 little-endian two-result hash.
// Hashes a message given as 12-byte blocks, one block per input transaction, and returns
// (c, b) as hash_primary / hash_secondary on the block marked last. The front end seeds
// and masks each block and writes it into a two-entry queue, so input is taken while the
// engine works and while a result waits in the output register. The engine runs one line
// of the mix per cycle: a middle block is absorbed and mixed, a last block is absorbed,
// run through 7 final-mix lines and its result loaded, an empty one absorbed and loaded.
module lookup3_little_endian_hash (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  l3h_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output l3h_pkg::out_t out_data_o
);
  import l3h_pkg::*;

  entry_t front_entry;
  entry_t queue_entry;
  logic   queue_full;
  logic   queue_valid;
  logic   queue_pop;
  logic   push;

  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && !queue_full;

  l3h_front u_front (
    .in_data_i (in_data_i),
    .entry_o   (front_entry)
  );

  l3h_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_entry),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_entry)
  );

  l3h_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (queue_valid),
    .entry_i       (queue_entry),
    .pop_o         (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

>>> hdl/l3h_checker.sv
// Port-level checks for the lookup3 hash block, bound to the top level.
`include "lookup3_little_endian_hash_defines.svh"

module l3h_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input l3h_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input l3h_pkg::out_t out_data_o
);
  import l3h_pkg::*;

  logic in_seen;
  assign in_seen = (in_data_i.byte_count <= 4'd15);

  // Result register holds a stalled transaction.
  `L3H_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // Queue only fills on an accepted transaction.
  `L3H_ASSERT_IMPLY(a_ready_fall, $fell(in_ready_o), $past(in_valid_i && in_ready_o && in_seen))
  // Result only leaves after it was taken.
  `L3H_ASSERT_IMPLY(a_out_drop, $fell(out_valid_o), $past(out_ready_i))

endmodule

bind lookup3_little_endian_hash l3h_checker u_l3h_checker (.*);

>>> test/lookup3_little_endian_hash_checker.sv
// Channel monitor, hash predictor and result comparison for the lookup3 hash block.
module lookup3_little_endian_hash_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  l3h_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  l3h_pkg::out_t out_data_i,
  output int            mismatch_count_o,
  output int            pending_o
);
  import l3h_pkg::*;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_state_t;

  mix_state_t mix_q;
  out_t       digest_q[$];
  out_t       want;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic mix_state_t churn(input mix_state_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = s.a;
    b = s.b;
    c = s.c;
    a = (a - c) ^ rot_left(c, 4);  c = c + b;
    b = (b - a) ^ rot_left(a, 6);  a = a + c;
    c = (c - b) ^ rot_left(b, 8);  b = b + a;
    a = (a - c) ^ rot_left(c, 16); c = c + b;
    b = (b - a) ^ rot_left(a, 19); a = a + c;
    c = (c - b) ^ rot_left(b, 4);  b = b + a;
    return {a, b, c};
  endfunction

  function automatic mix_state_t finalize(input mix_state_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = s.a;
    b = s.b;
    c = s.c;
    c = (c ^ b) - rot_left(b, 14);
    a = (a ^ c) - rot_left(c, 11);
    b = (b ^ a) - rot_left(a, 25);
    c = (c ^ b) - rot_left(b, 16);
    a = (a ^ c) - rot_left(c, 4);
    b = (b ^ a) - rot_left(a, 14);
    c = (c ^ b) - rot_left(b, 24);
    return {a, b, c};
  endfunction

  // low bytes of word idx that fall inside the first n bytes of the block
  function automatic logic [31:0] keep_bytes(input int unsigned n, input int unsigned idx);
    int unsigned base;
    base = idx * 4;
    if (n <= base) begin
      return 32'h0;
    end
    if (n - base >= 4) begin
      return 32'hffff_ffff;
    end
    return (32'd1 << (8 * (n - base))) - 32'd1;
  endfunction

  function automatic mix_state_t absorb(input mix_state_t st, input in_t blk);
    mix_state_t  s;
    logic [31:0] seed;
    int unsigned n;
    s = st;
    if (blk.first) begin
      seed = INIT_CONST + blk.total_length + blk.seed_primary;
      s.a = seed;
      s.b = seed;
      s.c = seed + blk.seed_secondary;
    end
    if (!blk.last) begin
      s.a = s.a + blk.word0;
      s.b = s.b + blk.word1;
      s.c = s.c + blk.word2;
      s = churn(s);
    end else begin
      n = 32'((blk.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : blk.byte_count);
      // empty message: seeded or leftover values go out untouched
      if (n != 0) begin
        s.a = s.a + (blk.word0 & keep_bytes(n, 0));
        s.b = s.b + (blk.word1 & keep_bytes(n, 1));
        s.c = s.c + (blk.word2 & keep_bytes(n, 2));
        s = finalize(s);
      end
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q = '0;
      digest_q.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      // a result leaves before any transaction accepted on the same edge can cause one
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $error("unexpected result: hash_primary %h, hash_secondary %h",
                 out_data_i.hash_primary, out_data_i.hash_secondary);
          mismatch_count_o++;
        end else begin
          want = digest_q.pop_front();
          if (out_data_i.hash_primary !== want.hash_primary) begin
            $error("hash_primary: expected %h, actual %h",
                   want.hash_primary, out_data_i.hash_primary);
            mismatch_count_o++;
          end
          if (out_data_i.hash_secondary !== want.hash_secondary) begin
            $error("hash_secondary: expected %h, actual %h",
                   want.hash_secondary, out_data_i.hash_secondary);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        mix_q = absorb(mix_q, in_data_i);
        if (in_data_i.last) begin
          want = {mix_q.c, mix_q.b};
          digest_q.push_back(want);
        end
      end
      pending_o = digest_q.size();
    end
  end

endmodule

>>> test/lookup3_little_endian_hash_tb.sv
// Stimulus, clock, reset and verdict for the lookup3 hash block.
module lookup3_little_endian_hash_tb;
  import l3h_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 750;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  int mismatch_count;
  int pending;
  int cycle_count;
  int items_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cycles;

  lookup3_little_endian_hash uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  lookup3_little_endian_hash_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lookup3_little_endian_hash_tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken  = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0 && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic in_t pack_block(input logic first, input logic last,
                                     input logic [31:0] w0, input logic [31:0] w1,
                                     input logic [31:0] w2, input logic [3:0] cnt,
                                     input logic [31:0] len, input logic [31:0] s1,
                                     input logic [31:0] s2);
    in_t blk;
    blk.first          = first;
    blk.last           = last;
    blk.word0          = w0;
    blk.word1          = w1;
    blk.word2          = w2;
    blk.byte_count     = cnt;
    blk.total_length   = len;
    blk.seed_primary   = s1;
    blk.seed_secondary = s2;
    return blk;
  endfunction

  // entered and left at a falling edge
  task automatic offer(input in_t blk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic offer_noise();
    offer(pack_block(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom,
                     $urandom, 4'($urandom_range(15)), $urandom, $urandom, $urandom));
  endtask

  // a message of len_bytes cut into blocks; a damaged one breaks one rule of framing
  task automatic send_message(input int unsigned len_bytes, input bit damaged);
    int unsigned nblk;
    int unsigned i;
    int unsigned flaw;
    logic [31:0] tl;
    logic [31:0] s1;
    logic [31:0] s2;
    in_t         blk;
    nblk = (len_bytes == 0) ? 1 : (len_bytes + 11) / 12;
    tl   = ($urandom_range(9) == 0) ? $urandom : len_bytes;
    s1   = $urandom;
    s2   = $urandom;
    flaw = $urandom_range(3);
    for (i = 0; i < nblk; i++) begin
      blk = pack_block(i == 0, i == nblk - 1, $urandom, $urandom, $urandom, BLOCK_BYTES,
                       $urandom, $urandom, $urandom);
      if (i == 0) begin
        blk.total_length   = tl;
        blk.seed_primary   = s1;
        blk.seed_secondary = s2;
      end
      if (blk.last) begin
        blk.byte_count = 4'(len_bytes - 12 * i);
      end
      if (damaged) begin
        case (flaw)
          0: blk.first = 1'b0;
          1: if (blk.last) blk.byte_count = 4'(13 + $urandom_range(2));
          2: if (!blk.last) blk.byte_count = 4'($urandom_range(15));
          default: if (blk.last && nblk > 1) blk.last = 1'b0;
        endcase
      end
      offer(blk);
    end
  endtask

  task automatic directed();
    int unsigned k;
    logic [3:0]  counts[7];
    counts = '{4'd1, 4'd3, 4'd4, 4'd5, 4'd8, 4'd11, 4'd12};
    // no first block straight after reset: continue from zero state
    offer(pack_block(1'b0, 1'b1, $urandom, $urandom, $urandom, BLOCK_BYTES, 0, 0, 0));
    // empty messages
    offer(pack_block(1'b1, 1'b1, '1, '1, '1, 4'd0, 32'd0, 32'd0, 32'd0));
    offer(pack_block(1'b1, 1'b1, '0, '0, '0, 4'd0, '1, '1, '1));
    offer(pack_block(1'b0, 1'b1, '1, '1, '1, 4'd0, '1, '1, '1));
    // single-block messages, all-ones data so the mask shows
    for (k = 0; k < 7; k++) begin
      offer(pack_block(1'b1, 1'b1, '1, '1, '1, counts[k], 32'(counts[k]), $urandom,
                       $urandom));
    end
    // count above twelve on a last block
    offer(pack_block(1'b1, 1'b1, '1, '1, '1, 4'd13, 32'd12, '1, '0));
    offer(pack_block(1'b1, 1'b1, '1, '1, '1, 4'd15, 32'd12, '0, '1));
    // three blocks, odd counts on middle blocks
    offer(pack_block(1'b1, 1'b0, '1, '1, '1, 4'd0, 32'd33, '1, '1));
    offer(pack_block(1'b0, 1'b0, '0, '0, '0, 4'd7, '0, '0, '0));
    offer(pack_block(1'b0, 1'b1, '1, '1, '1, 4'd9, '0, '0, '0));
    // message restarted before its last block
    offer(pack_block(1'b1, 1'b0, '0, '0, '0, BLOCK_BYTES, 32'd24, 32'd5, 32'd6));
    offer(pack_block(1'b1, 1'b1, $urandom, $urandom, $urandom, 4'd6, 32'd6, 32'd5, 32'd6));
    // hashing on after a last block without a new first
    offer(pack_block(1'b0, 1'b0, $urandom, $urandom, $urandom, BLOCK_BYTES, 0, 0, 0));
    offer(pack_block(1'b0, 1'b1, $urandom, $urandom, $urandom, 4'd10, 0, 0, 0));
  endtask

  initial begin
    int          phase;
    int          target;
    int unsigned r;
    int unsigned len_bytes;
    items_sent  = 0;
    hold_cycles = 0;
    tx_idle_pct = 17;
    rx_idle_pct = 87;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    rst_ni      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed();
    target = items_sent;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 17; rx_idle_pct = 87; end
        1: begin tx_idle_pct = 87; rx_idle_pct = 17; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; hold_cycles = 300; end
      endcase
      target += RANDOM_ITEMS / 3;
      while (items_sent < target) begin
        r = $urandom_range(99);
        len_bytes = ($urandom_range(4) == 0) ? $urandom_range(150) : $urandom_range(36);
        if (r < 10) begin
          offer_noise();
        end else begin
          send_message(len_bytes, r < 22);
        end
      end
      // sender pauses until every expected result is back
      in_valid_i <= 1'b0;
      wait (pending == 0);
      @(negedge clk_i);
    end

    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("lookup3_little_endian_hash_tb: clean");
    end else begin
      $display("lookup3_little_endian_hash_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/l3h_pkg.sv
hdl/l3h_front.sv
hdl/l3h_queue.sv
hdl/l3h_back.sv
hdl/lookup3_little_endian_hash.sv
hdl/l3h_checker.sv
test/lookup3_little_endian_hash_checker.sv
test/lookup3_little_endian_hash_tb.sv
